// File: sv/rbt_pkg.sv
// rbt_pkg: shared types, codes and widths for the retry backoff transition block
`timescale 1ns / 1ps

package rbt_pkg;

  localparam int COUNT_BITS = 16;
  localparam int TIME_BITS  = 48;
  localparam int DELAY_BITS = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int SHIFT_BITS = $clog2(DELAY_BITS + 1);

  localparam logic [DELAY_BITS-1:0] RETRY_BASE_RESET    = DELAY_BITS'(1);
  localparam logic [DELAY_BITS-1:0] DEFER_BASE_RESET    = DELAY_BITS'(1);
  localparam logic [DELAY_BITS-1:0] DELAY_CAP_RESET     = DELAY_BITS'(3600);
  localparam logic [COUNT_BITS-1:0] ATTEMPT_LIMIT_RESET = COUNT_BITS'(5);
  localparam logic [COUNT_BITS-1:0] DEFER_LIMIT_RESET   = COUNT_BITS'(20);

  typedef enum logic [2:0] {
    OUT_OK         = 3'd0,
    OUT_RETRYABLE  = 3'd1,
    OUT_TIMEOUT    = 3'd2,
    OUT_TERMINAL   = 3'd3,
    OUT_NOT_READY  = 3'd4,
    OUT_BUSY       = 3'd5,
    OUT_INCOMPLETE = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    ST_RESCHEDULED = 2'd0,
    ST_COMPLETED   = 2'd1,
    ST_DEAD_LETTER = 2'd2,
    ST_FAILED      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RETRY_BASE    = 3'd0,
    REG_DEFER_BASE    = 3'd1,
    REG_DELAY_CAP     = 3'd2,
    REG_ATTEMPT_LIMIT = 3'd3,
    REG_DEFER_LIMIT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]            outcome;
    logic [COUNT_BITS-1:0] attempts_done;
    logic [COUNT_BITS-1:0] deferrals_done;
    logic [TIME_BITS-1:0]  now_seconds;
    logic [COUNT_BITS-1:0] type_attempt_limit;
    logic                  type_attempt_default;
    logic [COUNT_BITS-1:0] type_defer_limit;
    logic                  type_defer_default;
  } in_data_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] new_attempts;
    logic [COUNT_BITS-1:0] new_deferrals;
    logic [TIME_BITS-1:0]  next_attempt_time;
  } out_data_t;

  typedef struct packed {
    logic [DELAY_BITS-1:0] retry_base;
    logic [DELAY_BITS-1:0] defer_base;
    logic [DELAY_BITS-1:0] delay_cap;
    logic [COUNT_BITS-1:0] default_attempt_limit;
    logic [COUNT_BITS-1:0] default_defer_limit;
  } cfg_t;

  // decode stage to delay stage
  typedef struct packed {
    logic                  valid;
    status_t               status;
    logic [COUNT_BITS-1:0] new_attempts;
    logic [COUNT_BITS-1:0] new_deferrals;
    logic [TIME_BITS-1:0]  now_seconds;
    logic                  do_delay;
    logic [DELAY_BITS-1:0] base;
    logic                  steps_over;
    logic [SHIFT_BITS-1:0] shamt;
  } dec_stage_t;

  // delay stage to sum stage
  typedef struct packed {
    logic                  valid;
    status_t               status;
    logic [COUNT_BITS-1:0] new_attempts;
    logic [COUNT_BITS-1:0] new_deferrals;
    logic [TIME_BITS-1:0]  now_seconds;
    logic [DELAY_BITS-1:0] delay;
  } dly_stage_t;

endpackage

// File: sv/rbt_decode.sv
// rbt_decode: outcome decode, counter update, limit check and shift setup
`timescale 1ns / 1ps

module rbt_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_beat,
  input  rbt_pkg::in_data_t  in_data,
  input  rbt_pkg::cfg_t      cfg,
  output rbt_pkg::dec_stage_t dec
);

  rbt_pkg::dec_stage_t dec_r, dec_nxt;

  logic [rbt_pkg::COUNT_BITS-1:0] att_inc, def_inc, att_lim, def_lim, cnt, steps;

  always_comb begin
    att_inc = (&in_data.attempts_done) ? in_data.attempts_done
                                       : in_data.attempts_done + 1'b1;
    def_inc = (&in_data.deferrals_done) ? in_data.deferrals_done
                                        : in_data.deferrals_done + 1'b1;
    att_lim = in_data.type_attempt_default ? cfg.default_attempt_limit
                                           : in_data.type_attempt_limit;
    def_lim = in_data.type_defer_default ? cfg.default_defer_limit
                                         : in_data.type_defer_limit;

    dec_nxt               = '0;
    dec_nxt.valid         = in_beat;
    dec_nxt.status        = rbt_pkg::ST_RESCHEDULED;
    dec_nxt.new_attempts  = in_data.attempts_done;
    dec_nxt.new_deferrals = in_data.deferrals_done;
    dec_nxt.now_seconds   = in_data.now_seconds;
    cnt                   = '0;

    unique case (in_data.outcome) inside
      rbt_pkg::OUT_OK: begin
        dec_nxt.status = rbt_pkg::ST_COMPLETED;
      end
      rbt_pkg::OUT_TERMINAL: begin
        dec_nxt.status = rbt_pkg::ST_FAILED;
      end
      rbt_pkg::OUT_RETRYABLE, rbt_pkg::OUT_TIMEOUT: begin
        dec_nxt.new_attempts  = att_inc;
        dec_nxt.new_deferrals = '0;
        if (att_lim != '0 && att_inc >= att_lim) begin
          dec_nxt.status = rbt_pkg::ST_DEAD_LETTER;
        end else begin
          dec_nxt.do_delay = 1'b1;
          dec_nxt.base     = cfg.retry_base;
          cnt              = att_inc;
        end
      end
      rbt_pkg::OUT_NOT_READY, rbt_pkg::OUT_BUSY: begin
        dec_nxt.new_deferrals = def_inc;
        if (def_lim != '0 && def_inc >= def_lim) begin
          dec_nxt.status = rbt_pkg::ST_DEAD_LETTER;
        end else begin
          dec_nxt.do_delay = 1'b1;
          dec_nxt.base     = cfg.defer_base;
          cnt              = def_inc;
        end
      end
      rbt_pkg::OUT_INCOMPLETE: begin
        dec_nxt.new_deferrals = '0;
      end
      default: begin
      end
    endcase

    // doubling steps are one fewer than the count
    steps              = (cnt == '0) ? '0 : cnt - 1'b1;
    dec_nxt.steps_over = (steps > rbt_pkg::COUNT_BITS'(rbt_pkg::DELAY_BITS));
    dec_nxt.shamt      = steps[rbt_pkg::SHIFT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid <= 1'b0;
    end else begin
      dec_r.valid <= dec_nxt.valid;
    end
    dec_r.status        <= dec_nxt.status;
    dec_r.new_attempts  <= dec_nxt.new_attempts;
    dec_r.new_deferrals <= dec_nxt.new_deferrals;
    dec_r.now_seconds   <= dec_nxt.now_seconds;
    dec_r.do_delay      <= dec_nxt.do_delay;
    dec_r.base          <= dec_nxt.base;
    dec_r.steps_over    <= dec_nxt.steps_over;
    dec_r.shamt         <= dec_nxt.shamt;
  end

  assign dec = dec_r;

endmodule

// File: sv/rbt_delay.sv
// rbt_delay: capped doubling delay from base and shift count
`timescale 1ns / 1ps

module rbt_delay (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rbt_pkg::dec_stage_t                 dec,
  input  logic [rbt_pkg::DELAY_BITS-1:0]      delay_cap,
  output rbt_pkg::dly_stage_t                 dly
);

  localparam int WIDE_BITS = 2 * rbt_pkg::DELAY_BITS;

  rbt_pkg::dly_stage_t dly_r, dly_nxt;
  logic [WIDE_BITS-1:0] wide;
  logic [WIDE_BITS-1:0] cap_wide;

  always_comb begin
    wide     = {{rbt_pkg::DELAY_BITS{1'b0}}, dec.base} << dec.shamt;
    cap_wide = {{rbt_pkg::DELAY_BITS{1'b0}}, delay_cap};

    dly_nxt.valid         = dec.valid;
    dly_nxt.status        = dec.status;
    dly_nxt.new_attempts  = dec.new_attempts;
    dly_nxt.new_deferrals = dec.new_deferrals;
    dly_nxt.now_seconds   = dec.now_seconds;

    if (!dec.do_delay) begin
      dly_nxt.delay = '0;
    end else if (dec.base == '0 || dec.steps_over || wide > cap_wide) begin
      dly_nxt.delay = delay_cap;
    end else begin
      dly_nxt.delay = wide[rbt_pkg::DELAY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r.valid <= 1'b0;
    end else begin
      dly_r.valid <= dly_nxt.valid;
    end
    dly_r.status        <= dly_nxt.status;
    dly_r.new_attempts  <= dly_nxt.new_attempts;
    dly_r.new_deferrals <= dly_nxt.new_deferrals;
    dly_r.now_seconds   <= dly_nxt.now_seconds;
    dly_r.delay         <= dly_nxt.delay;
  end

  assign dly = dly_r;

endmodule

// File: sv/rbt_sum.sv
// rbt_sum: saturating time add and result register
`timescale 1ns / 1ps

module rbt_sum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rbt_pkg::dly_stage_t  dly,
  output logic                 out_valid,
  output rbt_pkg::out_data_t   out_data
);

  logic                      out_valid_r;
  rbt_pkg::out_data_t        out_data_r, out_data_nxt;
  logic [rbt_pkg::TIME_BITS:0] sum;

  always_comb begin
    sum = {1'b0, dly.now_seconds}
        + {{(rbt_pkg::TIME_BITS + 1 - rbt_pkg::DELAY_BITS){1'b0}}, dly.delay};
    out_data_nxt.status            = dly.status;
    out_data_nxt.new_attempts      = dly.new_attempts;
    out_data_nxt.new_deferrals     = dly.new_deferrals;
    out_data_nxt.next_attempt_time = sum[rbt_pkg::TIME_BITS] ? '1
                                                             : sum[rbt_pkg::TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dly.valid;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/retry_backoff_transition.sv
// retry_backoff_transition: top level of the capped exponential backoff transition
//
// one beat in: a task outcome with its attempt and deferral counts, the
// current time and the type's limits (in_data); a beat is taken at every
// clock edge where start is high and busy is low
// one beat out: next status, updated counters and next eligible time on
// out_data, marked by a one-cycle out_valid strobe
// each beat passes the three register stages (decode, capped shift, saturating
// add); one beat can enter every cycle, so throughput is one per cycle
// busy stays low: the pipeline never holds, and the receiver cannot stall it,
// so every result is shown exactly once, in order of entry
// configuration writes go through cfg_valid/cfg_ready with a register index
// and data; cfg_ready is always high; write only while no beat is in flight
// synchronous reset clears the pipeline valid bits and loads the register
// defaults (bases 1, cap 3600, attempt limit 5, deferral limit 20)
`timescale 1ns / 1ps

module retry_backoff_transition (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  rbt_pkg::in_data_t                    in_data,
  output logic                                 out_valid,
  output rbt_pkg::out_data_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rbt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [rbt_pkg::DELAY_BITS-1:0]       cfg_data
);

  rbt_pkg::cfg_t       cfg_r, cfg_nxt;
  rbt_pkg::dec_stage_t dec;
  rbt_pkg::dly_stage_t dly;
  logic                in_beat;

  // the pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_beat   = start && !busy;

  // register file write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rbt_pkg::REG_RETRY_BASE:    cfg_nxt.retry_base = cfg_data;
        rbt_pkg::REG_DEFER_BASE:    cfg_nxt.defer_base = cfg_data;
        rbt_pkg::REG_DELAY_CAP:     cfg_nxt.delay_cap  = cfg_data;
        rbt_pkg::REG_ATTEMPT_LIMIT:
          cfg_nxt.default_attempt_limit = cfg_data[rbt_pkg::COUNT_BITS-1:0];
        rbt_pkg::REG_DEFER_LIMIT:
          cfg_nxt.default_defer_limit = cfg_data[rbt_pkg::COUNT_BITS-1:0];
        default: begin
          // index beyond the register list: write ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_base            <= rbt_pkg::RETRY_BASE_RESET;
      cfg_r.defer_base            <= rbt_pkg::DEFER_BASE_RESET;
      cfg_r.delay_cap             <= rbt_pkg::DELAY_CAP_RESET;
      cfg_r.default_attempt_limit <= rbt_pkg::ATTEMPT_LIMIT_RESET;
      cfg_r.default_defer_limit   <= rbt_pkg::DEFER_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stage 1: outcome decode, saturating counters, limit compare
  rbt_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_beat),
    .in_data (in_data),
    .cfg     (cfg_r),
    .dec     (dec)
  );

  // stage 2: base shifted by the doubling steps, clipped at the cap
  rbt_delay u_delay (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec),
    .delay_cap (cfg_r.delay_cap),
    .dly       (dly)
  );

  // stage 3: now plus delay, saturating, into the result register
  rbt_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .dly       (dly),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: sv/rbt_checker.sv
// rbt_checker: port-level assertions for the retry backoff transition, with bind
`timescale 1ns / 1ps

module rbt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input rbt_pkg::in_data_t                in_data,
  input logic                             out_valid,
  input rbt_pkg::out_data_t               out_data
);

  // every accepted beat gives one result
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted beat gave no result");

  // no result without an earlier accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without accepted beat");

  // completion leaves the attempt counter and time untouched
  a_completed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == rbt_pkg::ST_COMPLETED) |->
      (out_data.new_attempts == $past(in_data.attempts_done, 3) &&
       out_data.next_attempt_time == $past(in_data.now_seconds, 3)))
    else $error("completed result changed counters or time");

  // a reschedule never lands before the current time
  a_not_early: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == rbt_pkg::ST_RESCHEDULED) |->
      (out_data.next_attempt_time >= $past(in_data.now_seconds, 3)))
    else $error("rescheduled before current time");

  // dead letter only from retry or deferral outcomes
  a_dead_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == rbt_pkg::ST_DEAD_LETTER) |->
      ($past(in_data.outcome, 3) == rbt_pkg::OUT_RETRYABLE ||
       $past(in_data.outcome, 3) == rbt_pkg::OUT_TIMEOUT ||
       $past(in_data.outcome, 3) == rbt_pkg::OUT_NOT_READY ||
       $past(in_data.outcome, 3) == rbt_pkg::OUT_BUSY))
    else $error("dead letter from wrong outcome");

endmodule

bind retry_backoff_transition rbt_checker u_rbt_checker (.*);

// File: tb/retry_backoff_transition_test.sv
// retry_backoff_transition_test: self-checking bench for the backoff transition block
`timescale 1ns / 1ps

module retry_backoff_transition_test;
  import rbt_pkg::*;

  // outcome code with no defined meaning, and a register index nobody decodes
  localparam logic [2:0]              OUTCOME_UNDEFINED = 3'd7;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED        = 3'd7;

  localparam logic [TIME_BITS-1:0]  T_MAX = '1;
  localparam logic [COUNT_BITS-1:0] C_MAX = '1;

  localparam int PHASES          = 7;
  localparam int BEATS_PER_PHASE = 122;
  localparam int DRAIN_LIMIT     = 1000;
  localparam int SETTLE_CYCLES   = 8;

  // one line of the directed stimulus: either a register write or an input beat,
  // the latter optionally carrying a hand-worked result
  typedef struct {
    logic                    is_cfg;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [DELAY_BITS-1:0]   reg_val;
    in_data_t                item;
    logic                    by_hand;
    out_data_t               hand_result;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_data_t  in_data = '0;
  logic      out_valid;
  out_data_t out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [DELAY_BITS-1:0]   cfg_data = '0;

  // travels alongside in_data so the checker knows which beats were worked by hand
  logic      hand_checked = 1'b0;
  out_data_t hand_expect = '0;

  // bench copy of the register file
  logic [DELAY_BITS-1:0] set_retry_base;
  logic [DELAY_BITS-1:0] set_defer_base;
  logic [DELAY_BITS-1:0] set_delay_cap;
  logic [COUNT_BITS-1:0] set_attempt_limit;
  logic [COUNT_BITS-1:0] set_defer_limit;

  out_data_t pending_transitions[$];
  plan_row_t plan[$];
  int        mismatch_count = 0;
  int        burst_left = 0;

  retry_backoff_transition u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioural predictor
  // ---------------------------------------------------------------------------

  // saturating counter bump
  function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
    return (v == C_MAX) ? v : v + 1'b1;
  endfunction

  // base doubled once per count beyond the first, clipped at the shared cap;
  // a zero base, or a shift past the delay width, goes straight to the cap
  function automatic logic [DELAY_BITS-1:0] backoff(logic [COUNT_BITS-1:0] n,
                                                    logic [DELAY_BITS-1:0] base);
    logic [COUNT_BITS-1:0]   steps;
    logic [2*DELAY_BITS-1:0] grown;
    steps = (n == '0) ? '0 : n - 1'b1;
    if (base == '0 || steps > COUNT_BITS'(DELAY_BITS)) return set_delay_cap;
    grown = {{DELAY_BITS{1'b0}}, base} << steps;
    return (grown > {{DELAY_BITS{1'b0}}, set_delay_cap}) ? set_delay_cap
                                                        : grown[DELAY_BITS-1:0];
  endfunction

  // time sum pinned at all ones on overflow
  function automatic logic [TIME_BITS-1:0] later_by(logic [TIME_BITS-1:0] now,
                                                    logic [DELAY_BITS-1:0] d);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, now} + {{(TIME_BITS+1-DELAY_BITS){1'b0}}, d};
    return sum[TIME_BITS] ? T_MAX : sum[TIME_BITS-1:0];
  endfunction

  function automatic out_data_t next_task_state(in_data_t it);
    out_data_t             r;
    logic [COUNT_BITS-1:0] att_lim;
    logic [COUNT_BITS-1:0] def_lim;
    att_lim = it.type_attempt_default ? set_attempt_limit : it.type_attempt_limit;
    def_lim = it.type_defer_default ? set_defer_limit : it.type_defer_limit;
    r.status            = ST_RESCHEDULED;
    r.new_attempts      = it.attempts_done;
    r.new_deferrals     = it.deferrals_done;
    r.next_attempt_time = it.now_seconds;
    case (it.outcome)
      OUT_OK:       r.status = ST_COMPLETED;
      OUT_TERMINAL: r.status = ST_FAILED;
      OUT_RETRYABLE, OUT_TIMEOUT: begin
        r.new_attempts  = bump(it.attempts_done);
        r.new_deferrals = '0;
        if (att_lim != '0 && r.new_attempts >= att_lim) begin
          r.status = ST_DEAD_LETTER;
        end else begin
          r.next_attempt_time = later_by(it.now_seconds,
                                         backoff(r.new_attempts, set_retry_base));
        end
      end
      OUT_NOT_READY, OUT_BUSY: begin
        r.new_deferrals = bump(it.deferrals_done);
        if (def_lim != '0 && r.new_deferrals >= def_lim) begin
          r.status = ST_DEAD_LETTER;
        end else begin
          r.next_attempt_time = later_by(it.now_seconds,
                                         backoff(r.new_deferrals, set_defer_base));
        end
      end
      OUT_INCOMPLETE: r.new_deferrals = '0;
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checker: register mirror, expectation queue and result compare, all on one
  // edge so a beat accepted and a result shown together stay in order
  // ---------------------------------------------------------------------------

  task automatic flag_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_data_t want;
    if (!rst_n) begin
      set_retry_base    = RETRY_BASE_RESET;
      set_defer_base    = DEFER_BASE_RESET;
      set_delay_cap     = DELAY_CAP_RESET;
      set_attempt_limit = ATTEMPT_LIMIT_RESET;
      set_defer_limit   = DEFER_LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RETRY_BASE:    set_retry_base = cfg_data;
          REG_DEFER_BASE:    set_defer_base = cfg_data;
          REG_DELAY_CAP:     set_delay_cap = cfg_data;
          REG_ATTEMPT_LIMIT: set_attempt_limit = cfg_data[COUNT_BITS-1:0];
          REG_DEFER_LIMIT:   set_defer_limit = cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        pending_transitions.push_back(hand_checked ? hand_expect : next_task_state(in_data));
      if (out_valid) begin
        if (pending_transitions.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected, got %0h", $time, out_data);
        end else begin
          want = pending_transitions.pop_front();
          flag_field("status", 64'(want.status), 64'(out_data.status));
          flag_field("new_attempts", 64'(want.new_attempts), 64'(out_data.new_attempts));
          flag_field("new_deferrals", 64'(want.new_deferrals), 64'(out_data.new_deferrals));
          flag_field("next_attempt_time", 64'(want.next_attempt_time),
                     64'(out_data.next_attempt_time));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_data_t item_of(logic [2:0] oc, logic [COUNT_BITS-1:0] att,
                                       logic [COUNT_BITS-1:0] dfr, logic [TIME_BITS-1:0] now,
                                       logic [COUNT_BITS-1:0] att_lim, logic att_dflt,
                                       logic [COUNT_BITS-1:0] def_lim, logic def_dflt);
    in_data_t it;
    it.outcome              = oc;
    it.attempts_done        = att;
    it.deferrals_done       = dfr;
    it.now_seconds          = now;
    it.type_attempt_limit   = att_lim;
    it.type_attempt_default = att_dflt;
    it.type_defer_limit     = def_lim;
    it.type_defer_default   = def_dflt;
    return it;
  endfunction

  function automatic out_data_t result_of(status_t st, logic [COUNT_BITS-1:0] na,
                                          logic [COUNT_BITS-1:0] nd, logic [TIME_BITS-1:0] nt);
    out_data_t r;
    r.status            = st;
    r.new_attempts      = na;
    r.new_deferrals     = nd;
    r.next_attempt_time = nt;
    return r;
  endfunction

  function automatic plan_row_t item_row(in_data_t it, logic by_hand, out_data_t r);
    plan_row_t row;
    row.is_cfg      = 1'b0;
    row.reg_idx     = '0;
    row.reg_val     = '0;
    row.item        = it;
    row.by_hand     = by_hand;
    row.hand_result = r;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx, logic [DELAY_BITS-1:0] val);
    plan_row_t row;
    row.is_cfg      = 1'b1;
    row.reg_idx     = idx;
    row.reg_val     = val;
    row.item        = '0;
    row.by_hand     = 1'b0;
    row.hand_result = '0;
    return row;
  endfunction

  // counts lean small so the doubling and the limit compares both get exercised,
  // with the odd full-range value and a few right at the top
  function automatic logic [COUNT_BITS-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return C_MAX - COUNT_BITS'($urandom_range(0, 2));
      2, 3:    return COUNT_BITS'($urandom);
      default: return COUNT_BITS'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return TIME_BITS'($urandom_range(0, 5000));
      1:       return T_MAX - TIME_BITS'($urandom);
      default: return TIME_BITS'({$urandom, $urandom});
    endcase
  endfunction

  function automatic in_data_t random_item();
    logic [2:0] oc;
    oc = ($urandom_range(0, 15) == 0) ? OUTCOME_UNDEFINED : 3'($urandom_range(0, 6));
    return item_of(oc, pick_count(), pick_count(), pick_time(),
                   pick_count(), 1'($urandom_range(0, 1)),
                   pick_count(), 1'($urandom_range(0, 1)));
  endfunction

  // sender works in bursts; a gap of random length opens each new burst
  task automatic offer(in_data_t it, logic by_hand, out_data_t hand);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        start     <= 1'b0;
        cfg_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start        <= 1'b1;
    cfg_valid    <= 1'b0;
    in_data      <= it;
    hand_checked <= by_hand;
    hand_expect  <= hand;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stops the sender and waits for every outstanding result beat
  task automatic drain_pipeline();
    int waited;
    waited = 0;
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending_transitions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DELAY_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [DELAY_BITS-1:0] rb, db, cap, al, dl;

    // directed table, reset register values: bases 1, cap 3600, limits 5 and 20
    plan.push_back(item_row(item_of(OUT_OK, 16'd3, 16'd2, 48'd1000, 16'd0, 1'b1, 16'd0, 1'b1),
                   1'b1, result_of(ST_COMPLETED, 16'd3, 16'd2, 48'd1000)));
    plan.push_back(item_row(item_of(OUT_TERMINAL, 16'd7, 16'd9, 48'd55, 16'd0, 1'b1, 16'd0, 1'b1),
                   1'b1, result_of(ST_FAILED, 16'd7, 16'd9, 48'd55)));
    // first retry waits the bare base
    plan.push_back(item_row(item_of(OUT_RETRYABLE, 16'd0, 16'd4, 48'd100, 16'd0, 1'b1, 16'd0, 1'b1),
                   1'b1, result_of(ST_RESCHEDULED, 16'd1, 16'd0, 48'd101)));
    plan.push_back(item_row(item_of(OUT_TIMEOUT, 16'd3, 16'd1, 48'd100, 16'd0, 1'b1, 16'd0, 1'b1),
                   1'b1, result_of(ST_RESCHEDULED, 16'd4, 16'd0, 48'd108)));
    // reaching the default attempt limit
    plan.push_back(item_row(item_of(OUT_RETRYABLE, 16'd4, 16'd6, 48'd100, 16'd0, 1'b1, 16'd0, 1'b1),
                   1'b1, result_of(ST_DEAD_LETTER, 16'd5, 16'd0, 48'd100)));
    plan.push_back(item_row(item_of(OUT_NOT_READY, 16'd2, 16'd0, 48'd0, 16'd0, 1'b1, 16'd0, 1'b1),
                   1'b1, result_of(ST_RESCHEDULED, 16'd2, 16'd1, 48'd1)));
    // reaching the default deferral limit
    plan.push_back(item_row(item_of(OUT_BUSY, 16'd2, 16'd19, 48'd40, 16'd0, 1'b1, 16'd0, 1'b1),
                   1'b1, result_of(ST_DEAD_LETTER, 16'd2, 16'd20, 48'd40)));
    // zero type limit means unbounded
    plan.push_back(item_row(item_of(OUT_BUSY, 16'd0, 16'd5, 48'd40, 16'd0, 1'b1, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd0, 16'd6, 48'd72)));
    plan.push_back(item_row(item_of(OUT_INCOMPLETE, 16'd9, 16'd30, 48'd77, 16'd0, 1'b1, 16'd0, 1'b1),
                   1'b1, result_of(ST_RESCHEDULED, 16'd9, 16'd0, 48'd77)));
    plan.push_back(item_row(item_of(OUTCOME_UNDEFINED, 16'd1, 16'd2, 48'd3, 16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd1, 16'd2, 48'd3)));
    // attempt counter pinned at all ones, shift far past the width
    plan.push_back(item_row(item_of(OUT_RETRYABLE, C_MAX, 16'd8, 48'd0, 16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, C_MAX, 16'd0, 48'd3600)));
    // deferral counter pinned and equal to an all-ones limit
    plan.push_back(item_row(item_of(OUT_NOT_READY, 16'd0, C_MAX, 48'd5, 16'd0, 1'b0, C_MAX, 1'b0),
                   1'b1, result_of(ST_DEAD_LETTER, 16'd0, C_MAX, 48'd5)));
    // just under and just over the cap
    plan.push_back(item_row(item_of(OUT_TIMEOUT, 16'd11, 16'd0, 48'd0, 16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd12, 16'd0, 48'd2048)));
    plan.push_back(item_row(item_of(OUT_TIMEOUT, 16'd12, 16'd0, 48'd0, 16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd13, 16'd0, 48'd3600)));
    // time sum overflowing, and landing one short of all ones
    plan.push_back(item_row(item_of(OUT_RETRYABLE, 16'd20, 16'd0, T_MAX, 16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd21, 16'd0, T_MAX)));
    plan.push_back(item_row(item_of(OUT_RETRYABLE, 16'd20, 16'd0, 48'hFFFF_FFFF_F1EE,
                                    16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd21, 16'd0, 48'hFFFF_FFFF_FFFE)));
    // type limit of one, then the same limit overridden by the default flag
    plan.push_back(item_row(item_of(OUT_RETRYABLE, 16'd0, 16'd0, 48'd10, 16'd1, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_DEAD_LETTER, 16'd1, 16'd0, 48'd10)));
    plan.push_back(item_row(item_of(OUT_RETRYABLE, 16'd0, 16'd0, 48'd10, 16'd1, 1'b1, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd1, 16'd0, 48'd11)));
    plan.push_back(item_row(item_of(OUT_OK, C_MAX, C_MAX, T_MAX, C_MAX, 1'b1, C_MAX, 1'b1),
                   1'b1, result_of(ST_COMPLETED, C_MAX, C_MAX, T_MAX)));
    plan.push_back(item_row(item_of(OUT_NOT_READY, C_MAX, 16'd3, 48'd1, 16'd0, 1'b1, 16'd0, 1'b1),
                   1'b1, result_of(ST_RESCHEDULED, C_MAX, 16'd4, 48'd9)));
    // shift of exactly the delay width
    plan.push_back(item_row(item_of(OUT_BUSY, 16'd0, 16'd32, 48'd0, 16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd0, 16'd33, 48'd3600)));
    // zero retry base goes to the cap
    plan.push_back(cfg_row(REG_RETRY_BASE, 32'd0));
    plan.push_back(item_row(item_of(OUT_RETRYABLE, 16'd2, 16'd0, 48'd10, 16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd3, 16'd0, 48'd3610)));
    // zero base with zero cap gives no delay at all
    plan.push_back(cfg_row(REG_DELAY_CAP, 32'd0));
    plan.push_back(item_row(item_of(OUT_RETRYABLE, 16'd2, 16'd0, 48'd10, 16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd3, 16'd0, 48'd10)));
    // base above the cap is clipped on the very first retry
    plan.push_back(cfg_row(REG_RETRY_BASE, 32'd5000));
    plan.push_back(cfg_row(REG_DELAY_CAP, 32'd4000));
    plan.push_back(item_row(item_of(OUT_TIMEOUT, 16'd0, 16'd0, 48'd10, 16'd0, 1'b0, 16'd0, 1'b0),
                   1'b1, result_of(ST_RESCHEDULED, 16'd1, 16'd0, 48'd4010)));
    // zero deferral base, left to the predictor
    plan.push_back(cfg_row(REG_DEFER_BASE, 32'd0));
    plan.push_back(item_row(item_of(OUT_NOT_READY, 16'd0, 16'd9, 48'h1234_5678_9ABC,
                                    16'd0, 1'b0, 16'd0, 1'b0), 1'b0, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_pipeline();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer(plan[i].item, plan[i].by_hand, plan[i].hand_result);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          rb = 32'd1; db = 32'd1; cap = 32'd3600; al = 32'd5; dl = 32'd20;
        end
        1: begin
          // zero bases against the widest cap, limits unbounded
          rb = '0; db = '0; cap = '1; al = '0; dl = '0;
        end
        2: begin
          // widest bases against a zero cap; limit writes carry junk upper bits
          rb = '1; db = '1; cap = '0; al = '1; dl = '1;
        end
        3: begin
          rb = 32'd3; db = 32'd7; cap = '1; al = 32'd1; dl = 32'd1;
        end
        4: begin
          rb = 32'd5000; db = 32'd9000; cap = 32'd4000; al = 32'd12; dl = 32'd30;
        end
        5: begin
          rb = $urandom; db = $urandom; cap = $urandom;
          al = $urandom_range(0, 40) | ($urandom & 32'hFFFF_0000);
          dl = $urandom_range(0, 40) | ($urandom & 32'hFFFF_0000);
        end
        default: begin
          rb = $urandom_range(0, 64); db = $urandom_range(0, 64);
          cap = $urandom_range(0, 1 << 20);
          al = $urandom_range(0, 40); dl = $urandom_range(0, 40);
        end
      endcase
      drain_pipeline();
      write_reg(REG_RETRY_BASE, rb);
      write_reg(REG_DEFER_BASE, db);
      write_reg(REG_DELAY_CAP, cap);
      write_reg(REG_ATTEMPT_LIMIT, al);
      write_reg(REG_DEFER_LIMIT, dl);
      // an index past the register file must change nothing
      if (ph == 5) write_reg(REG_UNUSED, $urandom);
      for (int n = 0; n < BEATS_PER_PHASE; n++) offer(random_item(), 1'b0, '0);
    end

    drain_pipeline();
    // wait on to catch any stray result beat
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_transitions.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d result beats never arrived", $time, pending_transitions.size());
    end
    if (mismatch_count == 0) begin
      $display("retry_backoff_transition_test: done, clean");
    end else begin
      $display("retry_backoff_transition_test: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("retry_backoff_transition_test: done, errors");
    $finish;
  end

endmodule

// File: retry_backoff_transition.f
sv/rbt_pkg.sv
sv/rbt_decode.sv
sv/rbt_delay.sv
sv/rbt_sum.sv
sv/retry_backoff_transition.sv
sv/rbt_checker.sv
tb/retry_backoff_transition_test.sv
